[rtl/sync_frame_deframer_port_filter_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sync frame deframer with port filter
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SYNC_FRAME_DEFRAMER_PORT_FILTER_UNIT_ASSERT_SVH
`define SYNC_FRAME_DEFRAMER_PORT_FILTER_UNIT_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define SFDPF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sfdpf assertion failed: implication");

// Condition must never hold.
`define SFDPF_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("sfdpf assertion failed: forbidden condition");

`endif

[rtl/sfdpf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdpf_pkg
// Shared constants, port table and result type of the sync frame deframer.
// ----------------------------------------------------------------------------
package sfdpf_pkg;

  // Frame layout
  localparam int unsigned FRAME_BYTES = 256;
  localparam int unsigned PORT_OFFSET = 24;
  localparam int unsigned SYNC_LEN    = 4;

  // Port filter and ring defaults
  localparam int unsigned NUM_PORTS   = 18;
  localparam int unsigned TABLE_LEN   = 18;
  localparam int unsigned RING_SLOTS  = 8;

  // Sync pattern, one byte per hunt position
  function automatic logic [7:0] sync_byte(logic [1:0] pos);
    logic [7:0] val;
    case (pos)
      2'd0:    val = 8'h11;
      2'd1:    val = 8'h22;
      2'd2:    val = 8'h33;
      2'd3:    val = 8'h44;
      default: val = 8'h11;
    endcase
    return val;
  endfunction

  // Destination port table
  function automatic logic [15:0] port_entry(int unsigned k);
    logic [15:0] val;
    case (k)
      0:       val = 16'h9002;
      1:       val = 16'h7000;
      2:       val = 16'h8000;
      3:       val = 16'h9000;
      4:       val = 16'h9100;
      5:       val = 16'h9200;
      6:       val = 16'h9300;
      7:       val = 16'h9400;
      8:       val = 16'h9500;
      9:       val = 16'h9600;
      10:      val = 16'h9700;
      11:      val = 16'h6000;
      12:      val = 16'h6200;
      13:      val = 16'h6100;
      14:      val = 16'h6400;
      15:      val = 16'h6600;
      16:      val = 16'h6300;
      17:      val = 16'h6700;
      default: val = 16'h0000;
    endcase
    return val;
  endfunction

  // One result request
  typedef struct packed {
    logic        byte_taken;
    logic [7:0]  byte_index;
    logic [7:0]  byte_out;
    logic        frame_end;
    logic        forward;
    logic [15:0] dest_port;
    logic [2:0]  frame_slot;
  } result_t;

endpackage

[rtl/sfdpf_port_match.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdpf_port_match
// Parallel compare of a destination port against the first NUM_PORTS table
// entries.
// ----------------------------------------------------------------------------
module sfdpf_port_match #(
  parameter int unsigned NUM_PORTS = sfdpf_pkg::NUM_PORTS
) (
  input  logic [15:0] port_i,
  output logic        hit_o
);

  logic [NUM_PORTS-1:0] hit_vec;

  // Compare every listed entry; slots past the table never match
  for (genvar k = 0; k < NUM_PORTS; k++) begin : g_cmp
    if (k < sfdpf_pkg::TABLE_LEN) begin : g_entry
      assign hit_vec[k] = (port_i == sfdpf_pkg::port_entry(k));
    end else begin : g_none
      assign hit_vec[k] = 1'b0;
    end
  end

  assign hit_o = |hit_vec;

endmodule

[rtl/sfdpf_in_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdpf_in_reg
// Input register: holds one received byte until the core takes it.
// ----------------------------------------------------------------------------
module sfdpf_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_d, valid_q;
  logic [7:0] byte_d, byte_q;
  logic       accept;

  // Stall only while a held byte cannot move on
  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Load on accept, drain when the byte moves to the core
  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (accept) begin
      valid_d = 1'b1;
      byte_d  = rx_byte_i;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

[rtl/sfdpf_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdpf_core
// Sync hunt, frame position tracking, port capture and ring slot state.
// ----------------------------------------------------------------------------
module sfdpf_core #(
  parameter int unsigned NUM_PORTS  = sfdpf_pkg::NUM_PORTS,
  parameter int unsigned RING_SLOTS = sfdpf_pkg::RING_SLOTS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          byte_i,
  output sfdpf_pkg::result_t  result_o
);

  localparam int unsigned SlotW = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;

  logic [7:0]       pos_d, pos_q;
  logic [7:0]       port_low_d, port_low_q;
  logic [7:0]       port_high_d, port_high_q;
  logic [SlotW-1:0] slot_d, slot_q;

  logic [SlotW:0]   slot_inc;
  logic [SlotW+2:0] slot_ext;
  logic [8:0]       pos_inc;
  logic [15:0]      port_val;
  logic             port_hit;

  assign pos_inc  = {1'b0, pos_q} + 9'd1;
  assign slot_inc = {1'b0, slot_q} + {{SlotW{1'b0}}, 1'b1};
  assign slot_ext = {3'b000, slot_q};

  // Port as seen after this byte's capture
  always_comb begin
    port_val = {port_high_q, port_low_q};
    if (pos_q == 8'(sfdpf_pkg::PORT_OFFSET)) begin
      port_val[7:0] = byte_i;
    end
    if (pos_q == 8'(sfdpf_pkg::PORT_OFFSET + 1)) begin
      port_val[15:8] = byte_i;
    end
  end

  sfdpf_port_match #(
    .NUM_PORTS(NUM_PORTS)
  ) u_match (
    .port_i(port_val),
    .hit_o (port_hit)
  );

  // Hunt sync, collect payload, close frame
  always_comb begin
    pos_d       = pos_q;
    port_low_d  = port_low_q;
    port_high_d = port_high_q;
    slot_d      = slot_q;

    result_o            = '0;
    result_o.byte_out   = byte_i;
    result_o.frame_slot = slot_ext[2:0];

    if (pos_q < 8'(sfdpf_pkg::SYNC_LEN)) begin
      if (byte_i == sfdpf_pkg::sync_byte(pos_q[1:0])) begin
        result_o.byte_taken = 1'b1;
        result_o.byte_index = pos_q;
        pos_d               = pos_inc[7:0];
      end else begin
        pos_d = 8'd0;
      end
    end else begin
      result_o.byte_taken = 1'b1;
      result_o.byte_index = pos_q;
      port_low_d          = port_val[7:0];
      port_high_d         = port_val[15:8];
      if (pos_inc >= 9'(sfdpf_pkg::FRAME_BYTES)) begin
        result_o.frame_end = 1'b1;
        result_o.dest_port = port_val;
        result_o.forward   = port_hit;
        pos_d              = 8'd0;
        if (slot_inc >= (SlotW+1)'(RING_SLOTS)) begin
          slot_d = '0;
        end else begin
          slot_d = slot_inc[SlotW-1:0];
        end
      end else begin
        pos_d = pos_inc[7:0];
      end
    end
  end

  // Advance state only when a byte moves through
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 8'd0;
      port_low_q  <= 8'd0;
      port_high_q <= 8'd0;
      slot_q      <= '0;
    end else if (fire_i) begin
      pos_q       <= pos_d;
      port_low_q  <= port_low_d;
      port_high_q <= port_high_d;
      slot_q      <= slot_d;
    end
  end

endmodule

[rtl/sfdpf_out_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdpf_out_reg
// Result register: holds one result request until the receiver takes it.
// ----------------------------------------------------------------------------
module sfdpf_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  sfdpf_pkg::result_t result_i,
  output logic               advance_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sfdpf_pkg::result_t result_o
);

  logic               valid_d, valid_q;
  sfdpf_pkg::result_t data_d, data_q;

  // Room when empty or when the held result leaves this cycle
  assign advance_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (load_i) begin
      valid_d = 1'b1;
      data_d  = result_i;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;

endmodule

[rtl/sync_frame_deframer_port_filter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_frame_deframer_port_filter_unit
// Sync-word deframer for fixed-length frames with destination-port filter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel carries one received serial byte per request
//   (in_valid_i / in_stall_o / rx_byte_i). Output channel returns exactly
//   one result request per byte (out_valid_o / out_stall_i) with the byte
//   echoed, its frame index, and at frame end the destination port, the
//   forward flag and the ring slot the frame used.
//   From accept to out_valid_o a byte passes one input register, then the
//   core logic into the result register.
//   Throughput is one byte per cycle while the receiver does not stall;
//   the core state (frame position, captured port, ring slot) updates per byte.
//   Reset clears both registers' valid flags and returns the core to the
//   hunt for the first sync byte at ring slot 0.
//   While the receiver stalls, the held result stays put and one more byte
//   is still accepted if the input register is empty; after that in_stall_o
//   rises until the result is taken.
// ----------------------------------------------------------------------------
`include "sync_frame_deframer_port_filter_unit_assert.svh"

module sync_frame_deframer_port_filter_unit #(
  parameter int unsigned NUM_PORTS  = sfdpf_pkg::NUM_PORTS,
  parameter int unsigned RING_SLOTS = sfdpf_pkg::RING_SLOTS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        byte_taken_o,
  output logic [7:0]  byte_index_o,
  output logic [7:0]  byte_out_o,
  output logic        frame_end_o,
  output logic        forward_o,
  output logic [15:0] dest_port_o,
  output logic [2:0]  frame_slot_o
);

  logic               advance;
  logic               held_valid;
  logic [7:0]         held_byte;
  logic               fire;
  sfdpf_pkg::result_t core_result;
  sfdpf_pkg::result_t out_result;

  // Move a byte through the core when the result register has room
  assign fire = held_valid && advance;

  sfdpf_in_reg u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .rx_byte_i (rx_byte_i),
    .advance_i (advance),
    .valid_o   (held_valid),
    .byte_o    (held_byte)
  );

  sfdpf_core #(
    .NUM_PORTS (NUM_PORTS),
    .RING_SLOTS(RING_SLOTS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .byte_i  (held_byte),
    .result_o(core_result)
  );

  sfdpf_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire),
    .result_i   (core_result),
    .advance_o  (advance),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .result_o   (out_result)
  );

  // Unpack result fields
  assign byte_taken_o = out_result.byte_taken;
  assign byte_index_o = out_result.byte_index;
  assign byte_out_o   = out_result.byte_out;
  assign frame_end_o  = out_result.frame_end;
  assign forward_o    = out_result.forward;
  assign dest_port_o  = out_result.dest_port;
  assign frame_slot_o = out_result.frame_slot;

  // Checks
  `SFDPF_ASSERT_IMP(a_end_taken, out_valid_o && frame_end_o, byte_taken_o)
  `SFDPF_ASSERT_IMP(a_fwd_end, out_valid_o && forward_o, frame_end_o)
  `SFDPF_ASSERT_IMP(a_port_idle, out_valid_o && !frame_end_o, dest_port_o == 16'd0)
  `SFDPF_ASSERT_IMP(a_stall_full, in_stall_o, out_valid_o && out_stall_i)
  `SFDPF_ASSERT_NEVER(a_index_untaken, out_valid_o && !byte_taken_o && (byte_index_o != 8'd0))

endmodule
